FILE: rtl/core/sstc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package sstc_pkg;

  localparam int TABLE_ENTRIES_DEF    = 255;
  localparam int MAX_SYMBOL_BYTES_DEF = 8;
  localparam int LEAD_VALUES          = 256;
  localparam logic [7:0] ESC_BYTE     = 8'hFF;

  typedef enum logic [1:0] {
    FUNC_LOAD   = 2'd0,
    FUNC_ENCODE = 2'd1,
    FUNC_DECODE = 2'd2,
    FUNC_CLEAR  = 2'd3
  } func_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_SCAN,
    ST_DECODE,
    ST_CLEAR,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic [7:0]  code_in;
    logic [3:0]  window_len;
    logic [63:0] text_window;
    logic [3:0]  entry_len;
    logic [63:0] entry_symbol;
    logic [7:0]  entry_index;
  } in_item_t;

  typedef struct packed {
    logic [6:0]  pad;
    logic        bad_code;
    logic [3:0]  consumed;
    logic [3:0]  out_count;
    logic [63:0] out_bytes;
  } out_item_t;

  function automatic logic [63:0] byte_mask(input logic [3:0] n);
    logic [63:0] m;
    m = '0;
    for (int i = 0; i < 8; i++) begin
      if (4'(i) < n) begin
        m[i*8 +: 8] = 8'hFF;
      end
    end
    return m;
  endfunction

  function automatic logic [3:0] clamp_len(input logic [3:0] v, input logic [3:0] max_len);
    logic [3:0] r;
    if (v == 4'd0) begin
      r = 4'd1;
    end else if (v > max_len) begin
      r = max_len;
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/static_symbol_table_codec.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel        Direction  Handshake                   Payload
// s_tdata/tuser  in         s_tvalid, s_tready          one request transaction
// m_tdata        out        m_tvalid, m_tready          one result transaction
// symbol_count   in         symbol_count_we             symbol count register
//
// A load, a clear or a decode writes the result register in its LOOKUP, CLEAR or DECODE state;
// it then passes through EMIT back to IDLE, where the next transaction is taken. An encode goes
// through LOOKUP, SCAN while it scans entries, and EMIT, one read of the symbol memory per entry.
// Reset clears control state and the first-index valid bits at once; symbol entries stay
// undefined until loaded. A stalled result holds in the output register, and the next
// transaction is taken while it waits; only the following result waits for it.

module static_symbol_table_codec #(
  parameter int TABLE_ENTRIES    = sstc_pkg::TABLE_ENTRIES_DEF,
  parameter int MAX_SYMBOL_BYTES = sstc_pkg::MAX_SYMBOL_BYTES_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 s_tvalid,
  output logic                      s_tready,
  // entry_index, entry_symbol, entry_len, text_window, window_len, code_in
  input  wire sstc_pkg::in_item_t   s_tdata,
  // func
  input  wire logic [1:0]           s_tuser,
  output logic                      m_tvalid,
  input  wire logic                 m_tready,
  // out_bytes, out_count, consumed, bad_code, zero fill
  output sstc_pkg::out_item_t       m_tdata,
  input  wire logic                 symbol_count_we,
  input  wire logic [7:0]           symbol_count_wdata
);

  import sstc_pkg::*;

  localparam int IDX_W   = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int SYM_W   = 8 * MAX_SYMBOL_BYTES;
  localparam int ENTRY_W = SYM_W + 4;
  localparam logic [3:0] MAX_LEN = 4'(MAX_SYMBOL_BYTES);
  localparam logic [8:0] ENTRIES = 9'(TABLE_ENTRIES);

  state_t state, state_next;

  logic [ENTRY_W-1:0] sym_mem [TABLE_ENTRIES];
  logic [IDX_W-1:0]   fi_mem  [LEAD_VALUES];
  logic [LEAD_VALUES-1:0] fi_valid;

  logic [ENTRY_W-1:0] sym_rdata;
  logic [IDX_W-1:0]   fi_rdata;

  func_t       func;
  logic [7:0]  entry_index;
  logic [63:0] entry_symbol;
  logic [3:0]  entry_len;
  logic [63:0] text_window;
  logic [3:0]  window_len;
  logic [7:0]  code_in;
  logic [7:0]  lead;
  logic [7:0]  code, code_next;
  logic [7:0]  symbol_count;
  logic        escape_pending;
  out_item_t   res, res_next;

  logic               in_fire;
  logic [7:0]         lead_in;
  logic [IDX_W-1:0]   sym_rd_addr;
  logic               sym_we;
  logic [IDX_W-1:0]   sym_wr_addr;
  logic [ENTRY_W-1:0] sym_wdata;
  logic               fi_we;
  logic               fi_clear;
  logic               esc_set;
  logic               esc_clr;
  logic               out_load;

  logic [63:0] rd_sym;
  logic [3:0]  rd_len;
  logic [8:0]  fi_code;
  logic [8:0]  code_inc;
  logic        fi_ok;
  logic        inc_ok;
  logic        scan_stop;
  logic        scan_hit;
  logic        dec_ok;
  out_item_t   esc_res;

  assign in_fire = s_tvalid && s_tready;
  assign lead_in = (func_t'(s_tuser) == FUNC_LOAD) ? s_tdata.entry_symbol[7:0]
                                                   : s_tdata.text_window[7:0];

  assign rd_sym   = 64'(sym_rdata[SYM_W-1:0]);
  assign rd_len   = sym_rdata[ENTRY_W-1:SYM_W];
  assign fi_code  = 9'(fi_rdata);
  assign code_inc = {1'b0, code} + 9'd1;
  assign fi_ok    = fi_valid[lead] && (fi_code < {1'b0, symbol_count}) && (fi_code < ENTRIES);
  assign inc_ok   = (code_inc < {1'b0, symbol_count}) && (code_inc < ENTRIES);
  assign dec_ok   = ({1'b0, code_in} < {1'b0, symbol_count}) && ({1'b0, code_in} < ENTRIES);
  assign scan_stop = (rd_sym[7:0] != lead) && (rd_len != 4'd0);
  assign scan_hit  = (rd_len <= window_len) &&
                     (((rd_sym ^ text_window) & byte_mask(rd_len)) == 64'd0);

  always_comb begin
    esc_res           = '0;
    esc_res.out_bytes = {48'd0, lead, ESC_BYTE};
    esc_res.out_count = 4'd2;
    esc_res.consumed  = 4'd1;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_fire) begin
          unique case (func_t'(s_tuser))
            FUNC_LOAD, FUNC_ENCODE: state_next = ST_LOOKUP;
            FUNC_DECODE:            state_next = ST_DECODE;
            FUNC_CLEAR:             state_next = ST_CLEAR;
            default:                state_next = ST_IDLE;
          endcase
        end
      end
      ST_LOOKUP: begin
        if (func == FUNC_ENCODE && fi_ok) begin
          state_next = ST_SCAN;
        end else begin
          state_next = ST_EMIT;
        end
      end
      ST_SCAN: begin
        if (scan_stop || scan_hit || !inc_ok) begin
          state_next = ST_EMIT;
        end
      end
      ST_DECODE: state_next = ST_EMIT;
      ST_CLEAR:  state_next = ST_EMIT;
      ST_EMIT: begin
        if (!m_tvalid || m_tready) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    s_tready    = 1'b0;
    sym_rd_addr = code_inc[IDX_W-1:0];
    sym_we      = 1'b0;
    sym_wr_addr = entry_index[IDX_W-1:0];
    sym_wdata   = {entry_len, entry_symbol[SYM_W-1:0]};
    fi_we       = 1'b0;
    fi_clear    = 1'b0;
    esc_set     = 1'b0;
    esc_clr     = 1'b0;
    out_load    = 1'b0;
    code_next   = code;
    res_next    = res;
    unique case (state)
      ST_IDLE: begin
        s_tready    = 1'b1;
        sym_rd_addr = s_tdata.code_in[IDX_W-1:0];
      end
      ST_LOOKUP: begin
        res_next    = '0;
        sym_rd_addr = fi_rdata;
        if (func == FUNC_LOAD) begin
          if ({1'b0, entry_index} < ENTRIES) begin
            sym_we = 1'b1;
            if (!fi_valid[lead] || ({1'b0, entry_index} < fi_code)) begin
              fi_we = 1'b1;
            end
          end
        end else if (fi_ok) begin
          code_next = 8'(fi_code);
        end else begin
          res_next = esc_res;
        end
      end
      ST_SCAN: begin
        if (scan_stop) begin
          res_next = esc_res;
        end else if (scan_hit) begin
          res_next           = '0;
          res_next.out_bytes = 64'(code);
          res_next.out_count = 4'd1;
          res_next.consumed  = rd_len;
        end else if (inc_ok) begin
          code_next = code_inc[7:0];
        end else begin
          res_next = esc_res;
        end
      end
      ST_DECODE: begin
        res_next = '0;
        if (escape_pending) begin
          res_next.out_bytes = 64'(code_in);
          res_next.out_count = 4'd1;
          esc_clr            = 1'b1;
        end else if (code_in == ESC_BYTE) begin
          esc_set = 1'b1;
        end else if (dec_ok) begin
          res_next.out_bytes = rd_sym & byte_mask(rd_len);
          res_next.out_count = rd_len;
        end else begin
          res_next.bad_code = 1'b1;
        end
      end
      ST_CLEAR: begin
        res_next = '0;
        fi_clear = 1'b1;
      end
      ST_EMIT: begin
        out_load = !m_tvalid || m_tready;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    sym_rdata <= sym_mem[sym_rd_addr];
    if (sym_we) begin
      sym_mem[sym_wr_addr] <= sym_wdata;
    end
  end

  always_ff @(posedge clk) begin
    fi_rdata <= fi_mem[lead_in];
    if (fi_we) begin
      fi_mem[lead] <= entry_index[IDX_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      func         <= func_t'(s_tuser);
      entry_index  <= s_tdata.entry_index;
      entry_len    <= clamp_len(s_tdata.entry_len, MAX_LEN);
      entry_symbol <= s_tdata.entry_symbol & byte_mask(clamp_len(s_tdata.entry_len, MAX_LEN));
      text_window  <= s_tdata.text_window;
      window_len   <= clamp_len(s_tdata.window_len, MAX_LEN);
      code_in      <= s_tdata.code_in;
      lead         <= lead_in;
    end
    code <= code_next;
    res  <= res_next;
    if (out_load) begin
      m_tdata <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      fi_valid       <= '0;
      escape_pending <= 1'b0;
      symbol_count   <= 8'd0;
      m_tvalid       <= 1'b0;
    end else begin
      state <= state_next;
      if (fi_clear) begin
        fi_valid <= '0;
      end else if (fi_we) begin
        fi_valid[lead] <= 1'b1;
      end
      if (esc_set) begin
        escape_pending <= 1'b1;
      end else if (esc_clr) begin
        escape_pending <= 1'b0;
      end
      if (symbol_count_we) begin
        symbol_count <= symbol_count_wdata;
      end
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire
